[hw/rtl/ccl_pkg.sv]
// ---------------------------------------------------------------------------
// ccl_pkg
// Shared types and constants of the command class list parser.
// ---------------------------------------------------------------------------
package ccl_pkg;

  // list capacity in entries, per list
  localparam logic [7:0] ListCapacity = 8'd128;

  // lowest first byte of a two-byte item, and the controlled mode marker
  localparam logic [7:0] ExtFirstMin  = 8'hF1;
  localparam logic [7:0] CtrlMarker   = 8'hEF;

  typedef enum logic [1:0] {
    MODE_INSECURE   = 2'd0,
    MODE_CONTROLLED = 2'd1,
    MODE_SECURE     = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_INSECURE = 2'd0,
    KIND_SECURE   = 2'd1,
    KIND_SUMMARY  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] class_value;
    logic [7:0] insecure_total;
    logic [7:0] secure_total;
    logic       overflow;
    logic       run_end;
  } result_t;

endpackage

[hw/rtl/command_class_list_parser.sv]
// ---------------------------------------------------------------------------
// command_class_list_parser
// Splits a node-info command class list into insecure and secure class items.
// ---------------------------------------------------------------------------
// Usage: bytes of the list enter on the input channel (in_valid_i/in_ready_o),
// final_byte_i marks the last byte of a list. Each input item causes zero to
// three result items on the output channel (out_valid_o/out_ready_i): class
// bytes routed to the insecure or secure list, and an end summary with both
// counts on the final byte. run_end_o flags the last result of an input item.
// Latency: results of an item appear in the cycle after it is accepted and
// leave one per cycle, while the receiver is ready, from a three-entry result buffer.
// Throughput: one item per cycle while items cause at most one result and the
// receiver is ready; an item with more results holds the buffer until they
// drain, so a new item is taken when the buffer is empty or its last entry is
// being taken. Items with no result go at one per cycle.
// Reset: mode returns to insecure, counts, held byte and overflow clear, the
// result buffer empties. The same state is restored after every final byte.
// A stalled receiver holds the current result, and the input side stalls
// until the buffer drains.
// ---------------------------------------------------------------------------
module command_class_list_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] list_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] class_value_o,
  output logic [7:0] insecure_total_o,
  output logic [7:0] secure_total_o,
  output logic       overflow_o,
  output logic       run_end_o
);

  // parser state
  ccl_pkg::mode_e mode_q, mode_d;
  logic [7:0]     held_byte_q, held_byte_d;
  logic           held_valid_q, held_valid_d;
  logic [7:0]     ins_cnt_q, ins_cnt_d;
  logic [7:0]     sec_cnt_q, sec_cnt_d;
  logic           ovf_q, ovf_d;

  // result buffer, entry zero is presented
  ccl_pkg::result_t ent_q [3];
  ccl_pkg::result_t ent_d [3];
  logic [1:0]       cnt_q;
  logic [1:0]       n_res;

  logic in_fire, out_fire;

  // routing helpers
  logic             do_route;
  logic [1:0]       route_n;
  logic [7:0]       byte_a, byte_b;
  logic [7:0]       route_cnt;
  logic [8:0]       route_sum;
  ccl_pkg::kind_e   route_kind;
  logic             route_on;
  logic [7:0]       cnt_1, cnt_2;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;

  assign kind_o           = ent_q[0].kind;
  assign class_value_o    = ent_q[0].class_value;
  assign insecure_total_o = ent_q[0].insecure_total;
  assign secure_total_o   = ent_q[0].secure_total;
  assign overflow_o       = ent_q[0].overflow;
  assign run_end_o        = ent_q[0].run_end;

  // parse one byte and build its results
  always_comb begin
    mode_d       = mode_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    ins_cnt_d    = ins_cnt_q;
    sec_cnt_d    = sec_cnt_q;
    ovf_d        = ovf_q;
    do_route     = 1'b0;
    route_n      = 2'd1;
    byte_a       = list_byte_i;
    byte_b       = list_byte_i;
    n_res        = 2'd0;
    for (int i = 0; i < 3; i++) begin
      ent_d[i] = '0;
    end

    // classify the byte
    if (held_valid_q) begin
      held_valid_d = 1'b0;
      held_byte_d  = '0;
      if (list_byte_i == 8'h00) begin
        mode_d = ccl_pkg::MODE_SECURE;
      end else begin
        do_route = 1'b1;
        route_n  = 2'd2;
        byte_a   = held_byte_q;
      end
    end else if (list_byte_i >= ccl_pkg::ExtFirstMin) begin
      if (!final_byte_i) begin
        held_byte_d  = list_byte_i;
        held_valid_d = 1'b1;
      end
    end else if (list_byte_i == ccl_pkg::CtrlMarker) begin
      mode_d = ccl_pkg::MODE_CONTROLLED;
    end else begin
      do_route = 1'b1;
    end

    // pick the target list
    case (mode_q)
      ccl_pkg::MODE_INSECURE: begin
        route_on   = 1'b1;
        route_cnt  = ins_cnt_q;
        route_kind = ccl_pkg::KIND_INSECURE;
      end
      ccl_pkg::MODE_SECURE: begin
        route_on   = 1'b1;
        route_cnt  = sec_cnt_q;
        route_kind = ccl_pkg::KIND_SECURE;
      end
      default: begin
        route_on   = 1'b0;
        route_cnt  = ins_cnt_q;
        route_kind = ccl_pkg::KIND_INSECURE;
      end
    endcase

    route_sum = {1'b0, route_cnt} + {7'd0, route_n};
    cnt_1     = route_cnt + 8'd1;
    cnt_2     = route_cnt + 8'd2;

    // emit class bytes, or drop at capacity
    if (do_route && route_on) begin
      if (route_sum > {1'b0, ccl_pkg::ListCapacity}) begin
        ovf_d = 1'b1;
      end else begin
        if (route_kind == ccl_pkg::KIND_INSECURE) begin
          ins_cnt_d = (route_n == 2'd2) ? cnt_2 : cnt_1;
        end else begin
          sec_cnt_d = (route_n == 2'd2) ? cnt_2 : cnt_1;
        end
        ent_d[0].kind           = route_kind;
        ent_d[0].class_value    = byte_a;
        ent_d[0].insecure_total = (route_kind == ccl_pkg::KIND_INSECURE) ? cnt_1 : ins_cnt_q;
        ent_d[0].secure_total   = (route_kind == ccl_pkg::KIND_SECURE) ? cnt_1 : sec_cnt_q;
        ent_d[0].overflow       = ovf_q;
        ent_d[1].kind           = route_kind;
        ent_d[1].class_value    = byte_b;
        ent_d[1].insecure_total = (route_kind == ccl_pkg::KIND_INSECURE) ? cnt_2 : ins_cnt_q;
        ent_d[1].secure_total   = (route_kind == ccl_pkg::KIND_SECURE) ? cnt_2 : sec_cnt_q;
        ent_d[1].overflow       = ovf_q;
        n_res                   = route_n;
      end
    end

    // end summary, then start over
    if (final_byte_i) begin
      ent_d[n_res].kind           = ccl_pkg::KIND_SUMMARY;
      ent_d[n_res].class_value    = '0;
      ent_d[n_res].insecure_total = ins_cnt_d;
      ent_d[n_res].secure_total   = sec_cnt_d;
      ent_d[n_res].overflow       = ovf_d;
      n_res                       = n_res + 2'd1;
      mode_d       = ccl_pkg::MODE_INSECURE;
      held_byte_d  = '0;
      held_valid_d = 1'b0;
      ins_cnt_d    = '0;
      sec_cnt_d    = '0;
      ovf_d        = 1'b0;
    end

    // flag the last result of this item
    if (n_res != 2'd0) begin
      ent_d[n_res - 2'd1].run_end = 1'b1;
    end
  end

  // parser state and buffer fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ccl_pkg::MODE_INSECURE;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      ins_cnt_q    <= '0;
      sec_cnt_q    <= '0;
      ovf_q        <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (in_fire) begin
        mode_q       <= mode_d;
        held_byte_q  <= held_byte_d;
        held_valid_q <= held_valid_d;
        ins_cnt_q    <= ins_cnt_d;
        sec_cnt_q    <= sec_cnt_d;
        ovf_q        <= ovf_d;
        cnt_q        <= n_res;
      end else if (out_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ent_q <= ent_d;
    end else if (out_fire) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

  // checks
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && final_byte_i) |=> (!held_valid_q && ins_cnt_q == 8'd0 &&
                                   sec_cnt_q == 8'd0 && !ovf_q))
    else $error("state not cleared after final item");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ins_cnt_q <= ccl_pkg::ListCapacity) && (sec_cnt_q <= ccl_pkg::ListCapacity))
    else $error("list count above capacity");

  a_last_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> ent_q[0].run_end)
    else $error("last buffered result lacks run_end");

  a_no_run_end_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 2'd1) |-> !ent_q[0].run_end)
    else $error("run_end before last result of item");

  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_fire)))
    else $error("item accepted over pending results");

endmodule
